// ----- rtl/assert_macros.svh -----
// Shared assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define WTC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define WTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/wtc_pkg.sv -----
package wtc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam int KW_COUNT = 20;
    localparam int OP_COUNT = 6;

    localparam logic [4:0] T_COMMENT = 5'd0;
    localparam logic [4:0] T_LITERAL = 5'd1;
    localparam logic [4:0] T_OP_BASE = 5'd2;
    localparam logic [4:0] T_KW_BASE = 5'd8;
    localparam logic [4:0] T_ARG     = 5'd28;
    localparam logic [4:0] T_IDENT   = 5'd29;

    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_LOW_X = "x";
    localparam logic [7:0] CH_UP_X  = "X";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_R = "r";
    localparam logic [7:0] CH_LOW_G = "g";

    localparam logic [7:0] OP_CHARS [OP_COUNT] = '{"+", "-", "*", "/", "%", "^"};

    // keyword text, padded with NUL to eight positions
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"d", "e", "f", "u", "n", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"x", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "q", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "r", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "u", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "w", "a", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "b", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "v", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", "i", "f", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd6, 4'd3, 4'd2, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd2, 4'd4, 4'd3, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd4, 4'd5
    };

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } wtc_char_t;

    typedef struct packed {
        logic [4:0]         token_type;
        logic signed [31:0] const_value;
        logic signed [31:0] arg_number;
    } wtc_token_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } wtc_q_stat_t;

endpackage

// ----- rtl/wtc_front.sv -----
module wtc_front
    import wtc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  wtc_char_t   char_word,
    input  wtc_q_stat_t q_stat,
    output logic        push,
    output wtc_token_t  push_word
);

    localparam int W = VALUE_WIDTH;
    localparam logic [W-1:0] MAG_LIM = {1'b1, {(W-1){1'b0}}};

    logic [2:0]          pos_reg, pos_next;
    logic [KW_COUNT-1:0] kw_reg, kw_next;
    logic [7:0]          first_reg, first_next;
    logic [7:0]          second_reg, second_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                hex_reg, hex_next;
    logic                stop_reg, stop_next;

    logic         accept;
    logic [7:0]   c;
    logic [7:0]   fc;
    logic [7:0]   sc;
    logic         do_feed;
    logic         feed_hex;
    logic         dig_dec;
    logic         dig_hex;
    logic [3:0]   dv;
    logic [W+3:0] prod;
    logic [W+3:0] sum;
    logic [W-1:0] sval;
    logic signed [63:0] sval_ext;
    logic [3:0]   word_len;
    logic         found;
    logic [4:0]   ttype;
    logic [31:0]  lit;
    logic [31:0]  argn;

    function automatic logic is_dec(input logic [7:0] ch);
        return (ch >= "0") && (ch <= "9");
    endfunction

    assign accept     = char_valid && !q_stat.full;
    assign char_stall = q_stat.full;
    assign c          = char_word.character;

    always_comb
    begin
        fc = (pos_reg == 3'd0) ? c : first_reg;
        sc = (pos_reg == 3'd1) ? c : second_reg;

        dig_dec = is_dec(c);
        dig_hex = dig_dec || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        if (dig_dec)
            dv = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            dv = 4'(c - "a" + 8'd10);
        else
            dv = 4'(c - "A" + 8'd10);

        neg_next = neg_reg;
        hex_next = hex_reg;
        stop_next = stop_reg;
        acc_next = acc_reg;
        do_feed = 1'b0;
        feed_hex = 1'b0;

        if (is_dec(fc) || fc == CH_MINUS)
        begin
            if (pos_reg == 3'd0 && c == CH_MINUS)
                neg_next = 1'b1;
            else if (pos_reg == 3'd1 && fc == CH_ZERO && (c == CH_LOW_X || c == CH_UP_X))
                hex_next = 1'b1;
            else
            begin
                do_feed = 1'b1;
                feed_hex = hex_reg;
            end
        end
        else if (fc == CH_LOW_A)
        begin
            if (pos_reg == 3'd2)
                hex_next = (sc == CH_LOW_R) && (c == CH_LOW_G);
            else if (pos_reg == 3'd3 && hex_reg)
            begin
                if (c == CH_MINUS)
                    neg_next = 1'b1;
                else if (c != CH_PLUS)
                    do_feed = 1'b1;
            end
            else if (pos_reg >= 3'd4 && hex_reg)
                do_feed = 1'b1;
        end

        // acc * base + d, saturating at the magnitude limit
        if (feed_hex)
            prod = {acc_reg, 4'b0000};
        else
            prod = {3'b000, acc_reg, 1'b0} + {1'b0, acc_reg, 3'b000};
        sum = prod + (W + 4)'(dv);

        if (do_feed && !stop_reg)
        begin
            if (!(feed_hex ? dig_hex : dig_dec))
                stop_next = 1'b1;
            else if (sum > {4'b0000, MAG_LIM})
                acc_next = MAG_LIM;
            else
                acc_next = sum[W-1:0];
        end

        if (neg_next)
            sval = ~acc_next + W'(1);
        else if (acc_next == MAG_LIM)
            sval = MAG_LIM - W'(1);
        else
            sval = acc_next;
        sval_ext = 64'(signed'(sval));

        for (int k = 0; k < KW_COUNT; k++)
            kw_next[k] = kw_reg[k] && ({1'b0, pos_reg} < KW_LEN[k]) &&
                         (KW_TEXT[k][pos_reg] == c);

        word_len = {1'b0, pos_reg} + 4'd1;
        ttype = T_IDENT;
        lit = 32'd0;
        argn = 32'd0;
        found = 1'b0;

        if (fc == CH_SEMI)
            ttype = T_COMMENT;
        else if (is_dec(fc) || (fc == CH_MINUS && is_dec(sc)))
        begin
            ttype = T_LITERAL;
            lit = sval_ext[31:0];
        end
        else
        begin
            // lowest keyword wins; operators take priority
            for (int k = KW_COUNT - 1; k >= 0; k--)
            begin
                if (kw_next[k] && KW_LEN[k] == word_len)
                begin
                    ttype = T_KW_BASE + 5'(k);
                    found = 1'b1;
                end
            end
            for (int k = 0; k < OP_COUNT; k++)
            begin
                if (fc == OP_CHARS[k])
                begin
                    ttype = T_OP_BASE + 5'(k);
                    found = 1'b1;
                end
            end
            if (!found && fc == CH_LOW_A && hex_next)
            begin
                ttype = T_ARG;
                argn = sval_ext[31:0];
            end
        end

        if (char_word.last_char)
        begin
            pos_next = 3'd0;
            kw_next = '1;
            first_next = 8'd0;
            second_next = 8'd0;
            acc_next = '0;
            neg_next = 1'b0;
            hex_next = 1'b0;
            stop_next = 1'b0;
        end
        else
        begin
            pos_next = (pos_reg == 3'd7) ? pos_reg : pos_reg + 3'd1;
            first_next = fc;
            second_next = sc;
        end
    end

    assign push = accept && char_word.last_char;
    assign push_word.token_type = ttype;
    assign push_word.const_value = signed'(lit);
    assign push_word.arg_number = signed'(argn);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 3'd0;
            kw_reg <= '1;
            first_reg <= 8'd0;
            second_reg <= 8'd0;
            acc_reg <= '0;
            neg_reg <= 1'b0;
            hex_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            kw_reg <= kw_next;
            first_reg <= first_next;
            second_reg <= second_next;
            acc_reg <= acc_next;
            neg_reg <= neg_next;
            hex_reg <= hex_next;
            stop_reg <= stop_next;
        end
    end

endmodule

// ----- rtl/wtc_queue.sv -----
module wtc_queue
    import wtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  wtc_token_t  push_word,
    input  logic        pop,
    output wtc_token_t  head_word,
    output wtc_q_stat_t q_stat
);

    wtc_token_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, wr_next;
    logic [Q_PTR_W-1:0] rd_reg, rd_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign head_word = mem_reg[rd_reg];
    assign q_stat.full = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.not_empty = (cnt_reg != '0);

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push)
            wr_next = (wr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_reg + Q_PTR_W'(1);
        if (pop)
            rd_next = (rd_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_reg + Q_PTR_W'(1);
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + Q_CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - Q_CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_word;
    end

endmodule

// ----- rtl/wtc_back.sv -----
module wtc_back
    import wtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  wtc_q_stat_t q_stat,
    input  wtc_token_t  head_word,
    output logic        pop,
    output logic        token_valid,
    input  logic        token_stall,
    output wtc_token_t  token_word
);

    logic       valid_reg, valid_next;
    wtc_token_t word_reg;
    logic       load;

    assign load = !valid_reg || !token_stall;
    assign pop = load && q_stat.not_empty;
    assign valid_next = load ? q_stat.not_empty : valid_reg;
    assign token_valid = valid_reg;
    assign token_word = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            word_reg <= head_word;
    end

endmodule

// ----- rtl/word_token_classifier_core.sv -----
// Takes one character word per cycle while char_stall is low, lexing it in
// place; a word's token is pushed into the two-entry queue when its final
// character is taken and then loaded into the output register, so a new
// character (and a new word) can enter every cycle the queue is not full.
// Each character gets the lexer update: keyword masks plus multiply-by-base
// accumulate, saturating. char_stall rises only while the queue is full.
`include "assert_macros.svh"

module word_token_classifier_core
    import wtc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  wtc_char_t  char_word,
    output logic       token_valid,
    input  logic       token_stall,
    output wtc_token_t token_word
);

    wtc_q_stat_t q_stat;
    logic        push;
    logic        pop;
    wtc_token_t  push_word;
    wtc_token_t  head_word;

    wtc_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .q_stat     (q_stat),
        .push       (push),
        .push_word  (push_word)
    );

    wtc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .q_stat    (q_stat)
    );

    wtc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .head_word   (head_word),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

    `WTC_ASSERT_IMPLIES(a_lit_zero, token_valid && token_word.token_type != T_LITERAL, token_word.const_value == 32'sd0)
    `WTC_ASSERT_IMPLIES(a_arg_zero, token_valid && token_word.token_type != T_ARG, token_word.arg_number == 32'sd0)
    `WTC_ASSERT_IMPLIES(a_type_range, token_valid, token_word.token_type <= T_IDENT)
    `WTC_ASSERT_NEXT(a_push_seen, push && !q_stat.not_empty && !token_valid, q_stat.not_empty)

endmodule

// ----- verif/wtc_token_checker.sv -----
module wtc_token_checker
    import wtc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic       char_stall,
    input  wtc_char_t  char_word,
    input  logic       token_valid,
    input  logic       token_stall,
    input  wtc_token_t token_word,
    output int         mismatches,
    output int         tokens_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MAG_LIMIT   = 64'd1 << (VALUE_WIDTH - 1);
    localparam int          MAX_REPORTS = 10;
    localparam string       OPERATORS   = "+-*/%^";

    logic [2:0]          char_pos;
    logic [KW_COUNT-1:0] kw_alive;
    logic [7:0]          first_ch;
    logic [7:0]          second_ch;
    logic [63:0]         magnitude;
    logic                minus_seen;
    logic                hex_or_arg;    // hex base for literals, "arg" prefix for a-words
    logic                number_done;
    wtc_token_t          expected_tokens[$];

    function automatic string keyword_name(input int k);
        case (k)
            0:  return "defun";
            1:  return "return";
            2:  return "and";
            3:  return "or";
            4:  return "not";
            5:  return "xor";
            6:  return "lt";
            7:  return "le";
            8:  return "eq";
            9:  return "ge";
            10: return "gt";
            11: return "drop";
            12: return "dup";
            13: return "swap";
            14: return "min";
            15: return "abs";
            16: return "avg";
            17: return "if";
            18: return "else";
            19: return "endif";
            default: return "";
        endcase
    endfunction

    function automatic bit is_decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int unsigned digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return 99;
    endfunction

    function automatic logic [31:0] signed_low();
        logic [63:0] v;
        v = magnitude;
        if (minus_seen)
            v = 64'd0 - magnitude;
        else if (v > MAG_LIMIT - 1)
            v = MAG_LIMIT - 1;
        return v[31:0];
    endfunction

    task automatic clear_word();
        char_pos    = '0;
        kw_alive    = '1;
        first_ch    = '0;
        second_ch   = '0;
        magnitude   = '0;
        minus_seen  = 1'b0;
        hex_or_arg  = 1'b0;
        number_done = 1'b0;
    endtask

    task automatic take_digit(input logic [7:0] c, input int unsigned base);
        int unsigned d;
        d = digit_of(c);
        if (number_done)
            return;
        if (d >= base)
            number_done = 1'b1;
        else if (magnitude > (MAG_LIMIT - d) / base)
            magnitude = MAG_LIMIT;
        else
            magnitude = magnitude * base + d;
    endtask

    task automatic lex_char(input logic [7:0] c, input logic final_c);
        int unsigned p;
        string       kw;
        wtc_token_t  tok;
        bit          found;
        p = char_pos;
        if (p == 0)
            first_ch = c;
        if (p == 1)
            second_ch = c;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            kw = keyword_name(k);
            if (p >= kw.len() || kw[p] != c)
                kw_alive[k] = 1'b0;
        end

        if (is_decimal(first_ch) || first_ch == CH_MINUS)
        begin
            if (p == 0 && c == CH_MINUS)
                minus_seen = 1'b1;
            else if (p == 1 && first_ch == CH_ZERO && (c == CH_LOW_X || c == CH_UP_X))
                hex_or_arg = 1'b1;
            else
                take_digit(c, hex_or_arg ? 16 : 10);
        end
        else if (first_ch == CH_LOW_A)
        begin
            if (p == 2)
                hex_or_arg = (second_ch == CH_LOW_R && c == CH_LOW_G);
            else if (p == 3 && hex_or_arg)
            begin
                if (c == CH_MINUS)
                    minus_seen = 1'b1;
                else if (c != CH_PLUS)
                    take_digit(c, 10);
            end
            else if (p >= 4 && hex_or_arg)
                take_digit(c, 10);
        end

        if (!final_c)
        begin
            if (char_pos != 3'd7)
                char_pos = char_pos + 3'd1;
            return;
        end

        tok = '0;
        tok.token_type = T_IDENT;
        found = 1'b0;
        if (first_ch == CH_SEMI)
            tok.token_type = T_COMMENT;
        else if (is_decimal(first_ch) || (first_ch == CH_MINUS && is_decimal(second_ch)))
        begin
            tok.token_type  = T_LITERAL;
            tok.const_value = signed_low();
        end
        else
        begin
            for (int k = 0; k < OPERATORS.len(); k++)
            begin
                if (!found && first_ch == OPERATORS[k])
                begin
                    tok.token_type = T_OP_BASE + 5'(k);
                    found = 1'b1;
                end
            end
            for (int k = 0; k < KW_COUNT; k++)
            begin
                kw = keyword_name(k);
                if (!found && kw_alive[k] && kw.len() == p + 1)
                begin
                    tok.token_type = T_KW_BASE + 5'(k);
                    found = 1'b1;
                end
            end
            if (!found && first_ch == CH_LOW_A && hex_or_arg)
            begin
                tok.token_type = T_ARG;
                tok.arg_number = signed_low();
            end
        end
        expected_tokens.push_back(tok);
        clear_word();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        wtc_token_t want;
        if (!rst_n)
        begin
            clear_word();
            expected_tokens.delete();
            mismatches     <= 0;
            tokens_pending <= 0;
        end
        else
        begin
            if (token_valid && !token_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: unexpected token: type %0d lit %0d arg %0d", $realtime,
                                 token_word.token_type, token_word.const_value,
                                 token_word.arg_number);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (want.token_type !== token_word.token_type
                        || want.const_value !== token_word.const_value
                        || want.arg_number !== token_word.arg_number)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display("%0t: token mismatch: expected type %0d lit %0d arg %0d, got type %0d lit %0d arg %0d",
                                     $realtime, want.token_type, want.const_value,
                                     want.arg_number, token_word.token_type,
                                     token_word.const_value, token_word.arg_number);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (char_valid && !char_stall)
                lex_char(char_word.character, char_word.last_char);
            tokens_pending <= expected_tokens.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wtc_pkg::*;

    localparam int IDLE_PCT       = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_CHARS   = 620;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       char_valid  = 1'b0;
    logic       char_stall;
    wtc_char_t  char_word   = '0;
    logic       token_valid;
    logic       token_stall = 1'b0;
    wtc_token_t token_word;
    logic       idling_on   = 1'b1;
    int         mismatches;
    int         tokens_pending;
    int         quiet_cycles = 0;
    int         chars_sent   = 0;
    logic [7:0] word_buf[$];

    word_token_classifier_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_word   (char_word),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

    wtc_token_checker i_token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_word      (char_word),
        .token_valid    (token_valid),
        .token_stall    (token_stall),
        .token_word     (token_word),
        .mismatches     (mismatches),
        .tokens_pending (tokens_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        token_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && !char_stall) || (token_valid && !token_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic put_char(input logic [7:0] c, input logic lc);
        while (idling_on && $urandom_range(99) < IDLE_PCT)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_word  <= {c, lc};
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (char_stall);
        chars_sent++;
    endtask

    task automatic send_buf();
        for (int i = 0; i < word_buf.size(); i++)
            put_char(word_buf[i], i == word_buf.size() - 1);
        word_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            word_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_buf();
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n)
            word_buf.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_digits(input int n, input bit hex);
        string hexset;
        hexset = "0123456789abcdefABCDEF";
        repeat (n)
        begin
            if (hex)
                word_buf.push_back(hexset[$urandom_range(21)]);
            else
                word_buf.push_back(8'("0" + $urandom_range(9)));
        end
    endtask

    task automatic add_keyword(input int k);
        for (int j = 0; j < KW_LEN[k]; j++)
            word_buf.push_back(KW_TEXT[k][j]);
    endtask

    // let the block run dry before going on
    task automatic wait_drained();
        char_valid <= 1'b0;
        @(posedge clk);
        while (tokens_pending != 0)
            @(posedge clk);
    endtask

    task automatic build_random_word();
        int kind;
        kind = $urandom_range(99);
        if (kind < 18)
        begin
            add_keyword($urandom_range(KW_COUNT - 1));
            case ($urandom_range(9))
                0: word_buf.push_back(8'($urandom_range(255)));
                1: void'(word_buf.pop_back());
                2: word_buf[$urandom_range(word_buf.size() - 1)] = 8'($urandom_range(97, 122));
                default: ;
            endcase
        end
        else if (kind < 26)
        begin
            word_buf.push_back(OP_CHARS[$urandom_range(OP_COUNT - 1)]);
            add_random_bytes($urandom_range(3));
        end
        else if (kind < 46)
        begin
            if ($urandom_range(1))
                word_buf.push_back(CH_MINUS);
            if ($urandom_range(9) == 0)
            begin
                word_buf.push_back(CH_ZERO);
                word_buf.push_back(CH_LOW_X);
            end
            add_digits(($urandom_range(3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6), 0);
            if ($urandom_range(3) == 0)
                add_random_bytes($urandom_range(1, 3));
        end
        else if (kind < 58)
        begin
            word_buf.push_back(CH_ZERO);
            word_buf.push_back($urandom_range(1) ? CH_LOW_X : CH_UP_X);
            add_digits(($urandom_range(3) == 0) ? $urandom_range(9, 11) : $urandom_range(4), 1);
            if ($urandom_range(4) == 0)
                add_random_bytes($urandom_range(1, 2));
        end
        else if (kind < 70)
        begin
            add_text("arg");
            if ($urandom_range(4) == 0)
                word_buf[$urandom_range(2)] = 8'($urandom_range(97, 122));
            case ($urandom_range(2))
                0: word_buf.push_back(CH_MINUS);
                1: word_buf.push_back(CH_PLUS);
                default: ;
            endcase
            add_digits(($urandom_range(3) == 0) ? $urandom_range(10, 12) : $urandom_range(3), 0);
            if ($urandom_range(6) == 0)
                add_random_bytes($urandom_range(1, 2));
        end
        else if (kind < 76)
        begin
            word_buf.push_back(CH_SEMI);
            add_random_bytes($urandom_range(6));
        end
        else if (kind < 88)
        begin
            repeat ($urandom_range(1, 10))
                word_buf.push_back(8'($urandom_range(97, 122)));
        end
        else
            add_random_bytes($urandom_range(1, 10));
    endtask

    initial
    begin : stimulus
        int  random_end;
        bit  mid_drain_done;
        mid_drain_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < KW_COUNT; k++)
        begin
            add_keyword(k);
            send_buf();
        end
        send_text("+");
        send_text("-");
        send_text("*");
        send_text("/");
        send_text("%");
        send_text("^x");
        send_text("+5");
        send_text(";");
        send_text(";defun");
        send_text("0");
        send_text("-0");
        send_text("2147483647");
        send_text("2147483648");
        send_text("-2147483648");
        send_text("-2147483649");
        send_text("99999999999");
        send_text("0xffffFFFF");
        send_text("0X7a");
        send_text("0x");
        send_text("-0x1f");
        send_text("12a3");
        send_text("arg");
        send_text("arg-");
        send_text("arg+15");
        send_text("arg-9999999999");
        send_text("arg12x4");
        send_text("argue");
        send_text("returns");
        send_text("defunct");
        send_text("endifx");
        send_text("4 2");
        word_buf.push_back(8'h00);
        add_text("7");
        send_buf();
        add_text("5");
        word_buf.push_back(8'h00);
        add_text("5");
        send_buf();
        word_buf.push_back(8'hff);
        send_buf();
        wait_drained();

        random_end = chars_sent + RANDOM_CHARS;
        while (chars_sent < random_end)
        begin
            idling_on <= !(chars_sent >= random_end - 500 && chars_sent < random_end - 380);
            if (!mid_drain_done && chars_sent >= random_end - 300)
            begin
                wait_drained();
                mid_drain_done = 1'b1;
            end
            build_random_word();
            send_buf();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && tokens_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wtc_pkg.sv
rtl/wtc_front.sv
rtl/wtc_queue.sv
rtl/wtc_back.sv
rtl/word_token_classifier_core.sv
verif/wtc_token_checker.sv
verif/tb_top.sv
